// ===== rtl/awds_pkg.sv =====
// Shared types and fixed widths for the approximate word distance scanner.
// No dependencies.
package awds_pkg;

   localparam int LETTER_W = 8;
   localparam int LIMIT_W  = 6;
   localparam int COUNT_W  = 16;
   // Enough for the largest distance the walk can reach with words of up to 63 bytes.
   localparam int DIST_W   = 7;

   // Request mode codes.
   localparam logic MODE_QUERY = 1'b0;
   localparam logic MODE_CAND  = 1'b1;

   typedef logic [LETTER_W-1:0] letter_type;
   typedef logic [LIMIT_W-1:0]  limit_type;
   typedef logic [COUNT_W-1:0]  count_type;
   typedef logic [DIST_W-1:0]   dist_type;

endpackage

// ===== rtl/approximate_word_distance_scan.sv =====
// Approximate word distance scanner, top level.
// Depends on awds_pkg and awds_word_ram.
//
// Usage:
//  - req_* carries one byte per request: req_mode 0 = query byte, 1 = candidate
//    byte; req_word_end marks the last byte of a word. A query byte arriving
//    when no query is open starts a new query and clears the word and match
//    counters. Bytes beyond MAX_LEN are dropped and reported through overlong.
//  - rsp_* returns one result per candidate word: distance (saturated at 63),
//    match flag, word number since the query load and running match count.
//  - csr_* writes match_limit (reset value 1); csr_ready is always high.
//    Write it only while the block is idle.
// Flow: a byte without word_end does not stall the input. A candidate's last
// byte stalls the input through setup, the walk and finish; each walk step
// (at most the longer word's length) reads both byte stores synchronously,
// then compares and updates. The result then sits in the output register,
// and bytes keep flowing while the receiver stalls; only the next
// candidate's result waits for it.
// Reset: lengths, counters, flags and match_limit are cleared/preset; the
// byte stores are not cleared (they are only read below the stored lengths).
module approximate_word_distance_scan #(
   parameter int MAX_LEN = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_mode,
   input  awds_pkg::letter_type req_letter,
   input  logic                 req_word_end,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [5:0]           rsp_word_distance,
   output logic                 rsp_is_match,
   output awds_pkg::count_type  rsp_word_number,
   output awds_pkg::count_type  rsp_match_total,
   output logic                 rsp_overlong,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  awds_pkg::limit_type  csr_match_limit
);
   import awds_pkg::*;

   localparam int LEN_W  = $clog2(MAX_LEN + 1);
   localparam int ADDR_W = $clog2(MAX_LEN);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SETUP  = 3'd1;
   localparam logic [2:0] ST_READ   = 3'd2;
   localparam logic [2:0] ST_CMP    = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   // control state
   logic [2:0]  state_ff, state_in;
   logic        query_open_ff, query_open_in;
   logic        cand_open_ff, cand_open_in;
   logic        cand_over_ff, cand_over_in;
   logic        overflow_ff, overflow_in;
   logic [LEN_W-1:0] qlen_ff, qlen_in;
   logic [LEN_W-1:0] clen_ff, clen_in;
   count_type   word_cnt_ff, word_cnt_in;
   count_type   match_cnt_ff, match_cnt_in;
   limit_type   limit_ff, limit_in;

   // walk state
   logic [LEN_W-1:0] long_len_ff, long_len_in;
   logic [LEN_W-1:0] short_len_ff, short_len_in;
   logic        equal_ff, equal_in;
   logic        cand_longer_ff, cand_longer_in;
   logic [LEN_W-1:0] i_ff, i_in;
   logic [LEN_W-1:0] j_ff, j_in;
   dist_type    dist_ff, dist_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [5:0]  rsp_dist_ff, rsp_dist_in;
   logic        rsp_match_ff, rsp_match_in;
   count_type   rsp_number_ff, rsp_number_in;
   count_type   rsp_total_ff, rsp_total_in;
   logic        rsp_over_ff, rsp_over_in;

   // memory ports
   logic              q_wr_en, c_wr_en, rd_en;
   logic [ADDR_W-1:0] q_wr_addr, c_wr_addr, q_rd_addr, c_rd_addr;
   letter_type        q_rd_data, c_rd_data;

   logic             req_accept;
   logic [LEN_W-1:0] q_base, c_base;
   logic             q_room, c_room;
   logic             out_free, hit;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid & ~req_stall;
   assign csr_ready  = 1'b1;

   assign q_base = query_open_ff ? qlen_ff : '0;
   assign c_base = cand_open_ff ? clen_ff : '0;
   assign q_room = (q_base < LEN_W'(MAX_LEN));
   assign c_room = (c_base < LEN_W'(MAX_LEN));

   assign q_wr_en   = req_accept & (req_mode == MODE_QUERY) & q_room;
   assign c_wr_en   = req_accept & (req_mode == MODE_CAND) & c_room;
   assign q_wr_addr = q_base[ADDR_W-1:0];
   assign c_wr_addr = c_base[ADDR_W-1:0];

   // long word is walked by i, short word by j; equal lengths keep i == j
   assign q_rd_addr = cand_longer_ff ? j_ff[ADDR_W-1:0] : i_ff[ADDR_W-1:0];
   assign c_rd_addr = cand_longer_ff ? i_ff[ADDR_W-1:0] : j_ff[ADDR_W-1:0];

   assign out_free = ~rsp_valid_ff | ~rsp_stall;
   assign hit      = (dist_ff <= {1'b0, limit_ff});

   always_comb begin
      state_in       = state_ff;
      query_open_in  = query_open_ff;
      cand_open_in   = cand_open_ff;
      cand_over_in   = cand_over_ff;
      overflow_in    = overflow_ff;
      qlen_in        = qlen_ff;
      clen_in        = clen_ff;
      word_cnt_in    = word_cnt_ff;
      match_cnt_in   = match_cnt_ff;
      limit_in       = limit_ff;
      long_len_in    = long_len_ff;
      short_len_in   = short_len_ff;
      equal_in       = equal_ff;
      cand_longer_in = cand_longer_ff;
      i_in           = i_ff;
      j_in           = j_ff;
      dist_in        = dist_ff;
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      rsp_dist_in    = rsp_dist_ff;
      rsp_match_in   = rsp_match_ff;
      rsp_number_in  = rsp_number_ff;
      rsp_total_in   = rsp_total_ff;
      rsp_over_in    = rsp_over_ff;
      rd_en          = 1'b0;

      if (csr_valid) begin
         limit_in = csr_match_limit;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_mode == MODE_QUERY)) begin
               if (!query_open_ff) begin
                  // new query: drop counters and any partial candidate
                  word_cnt_in  = '0;
                  match_cnt_in = '0;
                  cand_open_in = 1'b0;
                  clen_in      = '0;
                  cand_over_in = 1'b0;
                  overflow_in  = 1'b0;
               end
               if (q_room) begin
                  qlen_in = q_base + LEN_W'(1);
               end else begin
                  qlen_in     = q_base;
                  overflow_in = 1'b1;
               end
               query_open_in = ~req_word_end;
            end else if (req_accept) begin
               query_open_in = 1'b0;
               cand_over_in  = cand_open_ff ? cand_over_ff : 1'b0;
               if (c_room) begin
                  clen_in = c_base + LEN_W'(1);
               end else begin
                  clen_in      = c_base;
                  cand_over_in = 1'b1;
               end
               cand_open_in = ~req_word_end;
               if (req_word_end) begin
                  state_in = ST_SETUP;
               end
            end
         end
         ST_SETUP: begin
            cand_longer_in = (clen_ff > qlen_ff);
            equal_in       = (clen_ff == qlen_ff);
            long_len_in    = (clen_ff > qlen_ff) ? clen_ff : qlen_ff;
            short_len_in   = (clen_ff > qlen_ff) ? qlen_ff : clen_ff;
            if (clen_ff == qlen_ff) begin
               dist_in = '0;
            end else if (clen_ff > qlen_ff) begin
               dist_in = DIST_W'(clen_ff - qlen_ff - LEN_W'(1));
            end else begin
               dist_in = DIST_W'(qlen_ff - clen_ff - LEN_W'(1));
            end
            i_in     = '0;
            j_in     = '0;
            state_in = ST_READ;
         end
         ST_READ: begin
            if ((i_ff < long_len_ff) && (j_ff < short_len_ff)) begin
               rd_en    = 1'b1;
               state_in = ST_CMP;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_CMP: begin
            if (q_rd_data != c_rd_data) begin
               dist_in = dist_ff + DIST_W'(1);
               if (equal_ff) begin
                  j_in = j_ff + LEN_W'(1);
               end
            end else begin
               j_in = j_ff + LEN_W'(1);
            end
            i_in     = i_ff + LEN_W'(1);
            state_in = ST_READ;
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_dist_in   = (dist_ff > DIST_W'(63)) ? 6'd63 : dist_ff[5:0];
               rsp_match_in  = hit;
               rsp_number_in = word_cnt_ff;
               rsp_over_in   = overflow_ff | cand_over_ff;
               if (hit && (match_cnt_ff != '1)) begin
                  match_cnt_in = match_cnt_ff + COUNT_W'(1);
                  rsp_total_in = match_cnt_ff + COUNT_W'(1);
               end else begin
                  rsp_total_in = match_cnt_ff;
               end
               word_cnt_in = word_cnt_ff + COUNT_W'(1);
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         query_open_ff <= 1'b0;
         cand_open_ff  <= 1'b0;
         cand_over_ff  <= 1'b0;
         overflow_ff   <= 1'b0;
         qlen_ff       <= '0;
         clen_ff       <= '0;
         word_cnt_ff   <= '0;
         match_cnt_ff  <= '0;
         limit_ff      <= LIMIT_W'(1);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         query_open_ff <= query_open_in;
         cand_open_ff  <= cand_open_in;
         cand_over_ff  <= cand_over_in;
         overflow_ff   <= overflow_in;
         qlen_ff       <= qlen_in;
         clen_ff       <= clen_in;
         word_cnt_ff   <= word_cnt_in;
         match_cnt_ff  <= match_cnt_in;
         limit_ff      <= limit_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      long_len_ff    <= long_len_in;
      short_len_ff   <= short_len_in;
      equal_ff       <= equal_in;
      cand_longer_ff <= cand_longer_in;
      i_ff           <= i_in;
      j_ff           <= j_in;
      dist_ff        <= dist_in;
      rsp_dist_ff    <= rsp_dist_in;
      rsp_match_ff   <= rsp_match_in;
      rsp_number_ff  <= rsp_number_in;
      rsp_total_ff   <= rsp_total_in;
      rsp_over_ff    <= rsp_over_in;
   end

   awds_word_ram #(
      .DEPTH  (MAX_LEN),
      .ADDR_W (ADDR_W)
   ) u_query_ram (
      .clock   (clock),
      .wr_en   (q_wr_en),
      .wr_addr (q_wr_addr),
      .wr_data (req_letter),
      .rd_en   (rd_en),
      .rd_addr (q_rd_addr),
      .rd_data (q_rd_data)
   );

   awds_word_ram #(
      .DEPTH  (MAX_LEN),
      .ADDR_W (ADDR_W)
   ) u_cand_ram (
      .clock   (clock),
      .wr_en   (c_wr_en),
      .wr_addr (c_wr_addr),
      .wr_data (req_letter),
      .rd_en   (rd_en),
      .rd_addr (c_rd_addr),
      .rd_data (c_rd_data)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_word_distance = rsp_dist_ff;
   assign rsp_is_match      = rsp_match_ff;
   assign rsp_word_number   = rsp_number_ff;
   assign rsp_match_total   = rsp_total_ff;
   assign rsp_overlong      = rsp_over_ff;

endmodule

// ===== rtl/awds_word_ram.sv =====
// Word byte store: one write port, one read port, registered read data.
// Depends on awds_pkg.
module awds_word_ram #(
   parameter int DEPTH  = 32,
   parameter int ADDR_W = 5
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  awds_pkg::letter_type wr_data,
   input  logic                rd_en,
   input  logic [ADDR_W-1:0]   rd_addr,
   output awds_pkg::letter_type rd_data
);
   import awds_pkg::*;

   letter_type mem_ff [DEPTH];
   letter_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
